FILE: rtl/cfpp_pkg.sv
package cfpp_pkg;

   localparam int LENGTH_WIDTH_DEFAULT = 32;
   localparam int CHAR_WIDTH           = 8;
   localparam int POSITION_WIDTH       = 32;
   localparam int STATUS_WIDTH         = 2;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL  = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_M    = 8'h4D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_EQ   = 8'h3D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_X    = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_S    = 8'h53;
   localparam logic [CHAR_WIDTH-1:0] CHAR_H    = 8'h48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_D    = 8'h44;
   localparam logic [CHAR_WIDTH-1:0] CHAR_N    = 8'h4E;
   localparam logic [CHAR_WIDTH-1:0] CHAR_I    = 8'h49;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_OP   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NEGATIVE = 2'd2;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0]     cigar_char;
      logic [POSITION_WIDTH-1:0] align_position;
      logic                      reverse_strand;
   } req_type;

   typedef struct packed {
      logic [POSITION_WIDTH-1:0] five_prime_position;
      logic [STATUS_WIDTH-1:0]   status;
   } rsp_type;

endpackage

FILE: rtl/cigar_five_prime_position_top.sv
// Streams the CIGAR string of one alignment, one character per beat, and on the NUL
// terminator returns one beat with the unclipped 5' reference position and a status
// (ok, bad operation or trailing digits, negative position). A beat is taken every cycle:
// each character passes an input register and the accumulate logic, and a
// terminator's result is computed from the input register into an output register. The input
// side stalls only while a result waits in the output register and the next terminator is
// already held behind it. Operation lengths wrap at LENGTH_WIDTH bits; span and clip sums
// wrap at 32 bits.
module cigar_five_prime_position_top #(
   parameter int LENGTH_WIDTH = cfpp_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cfpp_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cfpp_pkg::rsp_type rsp
);

   localparam int PW = cfpp_pkg::POSITION_WIDTH;

   logic              s1_valid_ff, s1_valid_in;
   cfpp_pkg::req_type s1_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   cfpp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [LENGTH_WIDTH-1:0] length_accum_ff, length_accum_in;
   logic                    digits_pending_ff, digits_pending_in;
   logic [PW-1:0]           reference_span_ff, reference_span_in;
   logic [PW-1:0]           start_clip_ff, start_clip_in;
   logic [PW-1:0]           end_clip_ff, end_clip_in;
   logic                    match_seen_ff, match_seen_in;
   logic                    bad_op_seen_ff, bad_op_seen_in;

   logic [cfpp_pkg::CHAR_WIDTH-1:0] ch;
   logic                            is_term;
   logic                            out_free;
   logic                            s1_adv;
   logic                            rsp_load;
   logic [PW-1:0]                   op_len;
   logic [cfpp_pkg::CHAR_WIDTH-1:0] digit;
   logic [PW+1:0]                   rev_sum;

   assign ch       = s1_data_ff.cigar_char;
   assign is_term  = (ch == cfpp_pkg::CHAR_NUL);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_adv   = s1_valid_ff && (!is_term || out_free);
   assign rsp_load = s1_adv && is_term;
   assign req_ready = !s1_valid_ff || s1_adv;

   assign s1_valid_in  = (req_valid && req_ready) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign op_len  = PW'(length_accum_ff);
   assign digit   = ch - cfpp_pkg::CHAR_ZERO;
   assign rev_sum = {2'b00, s1_data_ff.align_position} + {2'b00, reference_span_ff}
                  + {2'b00, end_clip_ff};

   always_comb begin
      rsp_data_in.five_prime_position = '0;
      rsp_data_in.status              = cfpp_pkg::STATUS_OK;
      if (bad_op_seen_ff || digits_pending_ff) begin
         rsp_data_in.status = cfpp_pkg::STATUS_BAD_OP;
      end else if (!s1_data_ff.reverse_strand) begin
         if (s1_data_ff.align_position < start_clip_ff) begin
            rsp_data_in.status = cfpp_pkg::STATUS_NEGATIVE;
         end else begin
            rsp_data_in.five_prime_position = s1_data_ff.align_position - start_clip_ff;
         end
      end else begin
         if (rev_sum == '0) begin
            rsp_data_in.status = cfpp_pkg::STATUS_NEGATIVE;
         end else begin
            rsp_data_in.five_prime_position = PW'(rev_sum - (PW+2)'(1));
         end
      end
   end

   always_comb begin
      length_accum_in   = length_accum_ff;
      digits_pending_in = digits_pending_ff;
      reference_span_in = reference_span_ff;
      start_clip_in     = start_clip_ff;
      end_clip_in       = end_clip_ff;
      match_seen_in     = match_seen_ff;
      bad_op_seen_in    = bad_op_seen_ff;
      if (s1_adv) begin
         if (is_term) begin
            length_accum_in   = '0;
            digits_pending_in = 1'b0;
            reference_span_in = '0;
            start_clip_in     = '0;
            end_clip_in       = '0;
            match_seen_in     = 1'b0;
            bad_op_seen_in    = 1'b0;
         end else if (!bad_op_seen_ff) begin
            if (ch >= cfpp_pkg::CHAR_ZERO && ch <= cfpp_pkg::CHAR_NINE) begin
               length_accum_in   = (length_accum_ff << 3) + (length_accum_ff << 1)
                                 + LENGTH_WIDTH'(digit);
               digits_pending_in = 1'b1;
            end else begin
               case (ch) inside
                  cfpp_pkg::CHAR_M, cfpp_pkg::CHAR_EQ, cfpp_pkg::CHAR_X: begin
                     reference_span_in = reference_span_ff + op_len;
                     match_seen_in     = 1'b1;
                  end
                  cfpp_pkg::CHAR_S, cfpp_pkg::CHAR_H: begin
                     if (match_seen_ff) begin
                        end_clip_in = end_clip_ff + op_len;
                     end else begin
                        start_clip_in = start_clip_ff + op_len;
                     end
                  end
                  cfpp_pkg::CHAR_D, cfpp_pkg::CHAR_N: begin
                     reference_span_in = reference_span_ff + op_len;
                  end
                  cfpp_pkg::CHAR_I: begin
                  end
                  default: begin
                     bad_op_seen_in = 1'b1;
                  end
               endcase
               length_accum_in   = '0;
               digits_pending_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         length_accum_ff   <= '0;
         digits_pending_ff <= 1'b0;
         reference_span_ff <= '0;
         start_clip_ff     <= '0;
         end_clip_ff       <= '0;
         match_seen_ff     <= 1'b0;
         bad_op_seen_ff    <= 1'b0;
      end else begin
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         length_accum_ff   <= length_accum_in;
         digits_pending_ff <= digits_pending_in;
         reference_span_ff <= reference_span_in;
         start_clip_ff     <= start_clip_in;
         end_clip_ff       <= end_clip_in;
         match_seen_ff     <= match_seen_in;
         bad_op_seen_ff    <= bad_op_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_data_ff;

endmodule

FILE: rtl/cfpp_checker.sv
module cfpp_sva (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input cfpp_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cfpp_pkg::rsp_type rsp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the beat was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp))
      else $error("rsp payload changed while stalled");

   a_rsp_after_term: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && req.cigar_char == cfpp_pkg::CHAR_NUL, 2))
      else $error("result beat without a terminator two cycles earlier");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the output side is free");

   a_bad_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != cfpp_pkg::STATUS_OK |-> rsp.five_prime_position == '0)
      else $error("nonzero position with an error status");

endmodule

bind cigar_five_prime_position_top cfpp_sva u_cfpp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

FILE: verif/cfpp_checker.sv
`timescale 1ns / 1ps
module cfpp_checker #(
   parameter int LENGTH_WIDTH = cfpp_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  cfpp_pkg::req_type req,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  cfpp_pkg::rsp_type rsp,
   output int                outstanding,
   output int                fail_count
);

   localparam int PW = cfpp_pkg::POSITION_WIDTH;

   logic [LENGTH_WIDTH-1:0] op_length;
   logic                    digits_open;
   logic [PW-1:0]           ref_span;
   logic [PW-1:0]           start_clip;
   logic [PW-1:0]           end_clip;
   logic                    match_seen;
   logic                    bad_op;

   cfpp_pkg::rsp_type five_prime_q[$];

   function automatic void clear_record();
      op_length   = '0;
      digits_open = 1'b0;
      ref_span    = '0;
      start_clip  = '0;
      end_clip    = '0;
      match_seen  = 1'b0;
      bad_op      = 1'b0;
   endfunction

   // Advances the CIGAR state by one character; returns 1 when a result is due.
   function automatic bit five_prime_for_char(input cfpp_pkg::req_type beat,
                                              output cfpp_pkg::rsp_type res);
      logic [PW-1:0] op_len;
      logic [PW+1:0] rev_sum;
      res = '0;
      if (beat.cigar_char == cfpp_pkg::CHAR_NUL) begin
         if (bad_op || digits_open) begin
            res.status = cfpp_pkg::STATUS_BAD_OP;
         end else if (!beat.reverse_strand) begin
            if (beat.align_position < start_clip) begin
               res.status = cfpp_pkg::STATUS_NEGATIVE;
            end else begin
               res.status              = cfpp_pkg::STATUS_OK;
               res.five_prime_position = beat.align_position - start_clip;
            end
         end else begin
            rev_sum = (PW+2)'(beat.align_position) + (PW+2)'(ref_span)
                    + (PW+2)'(end_clip);
            if (rev_sum == '0) begin
               res.status = cfpp_pkg::STATUS_NEGATIVE;
            end else begin
               res.status              = cfpp_pkg::STATUS_OK;
               res.five_prime_position = PW'(rev_sum - (PW+2)'(1));
            end
         end
         clear_record();
         return 1'b1;
      end
      if (bad_op) return 1'b0;
      if (beat.cigar_char >= cfpp_pkg::CHAR_ZERO && beat.cigar_char <= cfpp_pkg::CHAR_NINE)
      begin
         op_length   = LENGTH_WIDTH'(op_length * LENGTH_WIDTH'(10)
                     + LENGTH_WIDTH'(beat.cigar_char - cfpp_pkg::CHAR_ZERO));
         digits_open = 1'b1;
         return 1'b0;
      end
      op_len = PW'(op_length);
      case (beat.cigar_char)
         cfpp_pkg::CHAR_M, cfpp_pkg::CHAR_EQ, cfpp_pkg::CHAR_X: begin
            ref_span   = ref_span + op_len;
            match_seen = 1'b1;
         end
         cfpp_pkg::CHAR_S, cfpp_pkg::CHAR_H: begin
            if (match_seen) end_clip = end_clip + op_len;
            else start_clip = start_clip + op_len;
         end
         cfpp_pkg::CHAR_D, cfpp_pkg::CHAR_N: ref_span = ref_span + op_len;
         cfpp_pkg::CHAR_I: ;
         default: bad_op = 1'b1;
      endcase
      op_length   = '0;
      digits_open = 1'b0;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      cfpp_pkg::rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         clear_record();
         five_prime_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (five_prime_q.size() == 0) begin
               $error("unexpected rsp beat: five_prime_position %0h status %0d",
                      rsp.five_prime_position, rsp.status);
               errs++;
            end else begin
               want = five_prime_q.pop_front();
               if (rsp.five_prime_position !== want.five_prime_position) begin
                  $error("five_prime_position: expected %0h, actual %0h",
                         want.five_prime_position, rsp.five_prime_position);
                  errs++;
               end
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp.status);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (five_prime_for_char(req, want)) five_prime_q.push_back(want);
         end
      end
      outstanding <= five_prime_q.size();
      fail_count  <= fail_count + errs;
   end

endmodule

FILE: verif/cigar_five_prime_position_top_tb.sv
`timescale 1ns / 1ps
module cigar_five_prime_position_top_tb;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic              req_ready;
   cfpp_pkg::req_type req        = '0;
   logic              rsp_valid;
   logic              rsp_ready  = 1'b0;
   cfpp_pkg::rsp_type rsp;
   logic              want_stall = 1'b0;
   logic              rsp_hold   = 1'b0;
   int                outstanding;
   int                fail_count;
   int                items_sent = 0;
   int                tx_quiet   = 0;

   cigar_five_prime_position_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   cfpp_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("cigar_five_prime_position_top_tb failed");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic string length_text();
      int    r;
      string s;
      r = $urandom_range(0, 99);
      s = "";
      if (r < 10) return s;
      if (r < 70) return $sformatf("%0d", $urandom_range(1, 150));
      if (r < 90) return $sformatf("%0d", $urandom_range(151, 2000000));
      // long digit runs can wrap the length accumulator
      repeat ($urandom_range(8, 14)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      return s;
   endfunction

   function automatic string random_cigar();
      string body_ops;
      string s;
      int    r;
      int    k;
      body_ops = "M=XDNI";
      s = "";
      r = $urandom_range(0, 99);
      if (r < 5) begin
         case ($urandom_range(0, 3))
            0: return "";
            1: return "0M";
            2: return "I";
            default: return "4H";
         endcase
      end
      repeat ($urandom_range(0, 2))
         s = {s, length_text(), ($urandom_range(0, 1) ? "S" : "H")};
      repeat ($urandom_range(1, 4))
         s = {s, length_text(), $sformatf("%c", body_ops[$urandom_range(0, 5)])};
      repeat ($urandom_range(0, 2))
         s = {s, length_text(), ($urandom_range(0, 1) ? "S" : "H")};
      if (r >= 85) begin
         k = $urandom_range(0, s.len());
         case ($urandom_range(0, 2))
            0: s = {s.substr(0, k - 1), $sformatf("%c", $urandom_range(1, 255)),
                    s.substr(k, s.len() - 1)};
            1: s = {s, $sformatf("%0d", $urandom_range(0, 999))};
            default: repeat ($urandom_range(1, 4))
               s = {s, $sformatf("%c", $urandom_range(1, 255))};
         endcase
      end
      return s;
   endfunction

   function automatic logic [cfpp_pkg::POSITION_WIDTH-1:0] pick_position();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 20);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 20);
         default: return $urandom_range(0, 5000);
      endcase
   endfunction

   task automatic send_beat(input logic [cfpp_pkg::CHAR_WIDTH-1:0] ch,
                            input logic [cfpp_pkg::POSITION_WIDTH-1:0] pos,
                            input logic rev);
      int gap;
      if (tx_quiet > 0) begin
         tx_quiet--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 199) == 0) tx_quiet = $urandom_range(40, 120);
         gap = idle_len();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= '{cigar_char: ch, align_position: pos, reverse_strand: rev};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_record(input string ops,
                              input logic [cfpp_pkg::POSITION_WIDTH-1:0] pos,
                              input logic rev);
      for (int i = 0; i < ops.len(); i++)
         send_beat(ops[i], $urandom, $urandom_range(0, 1));
      send_beat(cfpp_pkg::CHAR_NUL, pos, rev);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // result side: random backpressure, plus one long hold on request
   initial begin
      int gap;
      int quiet;
      quiet = 0;
      while (reset) @(posedge clock);
      forever begin
         if (want_stall && !rsp_hold) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= 1'b1;
            repeat (250) @(posedge clock);
         end else begin
            if (quiet > 0) begin
               quiet--;
               gap = 0;
            end else begin
               if ($urandom_range(0, 149) == 0) quiet = $urandom_range(40, 120);
               gap = idle_len();
            end
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      string                               s;
      logic [cfpp_pkg::POSITION_WIDTH-1:0] pos;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_record("", 32'hFFFF_FFFF, 1'b0);
      send_record("", 32'h0, 1'b1);
      send_record("5S9M", 32'd4, 1'b0);
      send_record("2M=XDNIH", 32'hFFFF_FFFF, 1'b1);
      send_record("90", $urandom, 1'b0);
      send_record("\3779M", $urandom, 1'b1);
      wait_drained();

      // hold the result side and keep terminators coming so the input backs up
      want_stall <= 1'b1;
      do @(posedge clock); while (!rsp_hold);
      tx_quiet = 1000;
      repeat (40) send_record(($urandom_range(0, 1) ? "" : "2M"), pick_position(),
                              $urandom_range(0, 1));
      tx_quiet = 0;

      while (items_sent < 1850) begin
         s = random_cigar();
         pos = (s.len() < 3 && $urandom_range(0, 1)) ? '0 : pick_position();
         send_record(s, pos, $urandom_range(0, 1));
         if ($urandom_range(0, 39) == 0) wait_drained();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("cigar_five_prime_position_top_tb passed");
      end else begin
         $display("cigar_five_prime_position_top_tb failed");
      end
      $finish;
   end

endmodule
